/* design/run_length_level_decoder_core_macros.svh */
// ----------------------------------------------------------------------------
// Run-length level decoder assertion macros
// Implication checks on the rising edge of clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_LEVEL_DECODER_CORE_MACROS_SVH
`define RUN_LENGTH_LEVEL_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RLLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RLLD_ASSERT_IMPLY(lbl, ante, cons, msg)

`define RLLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/rlld_pkg.sv */
// ----------------------------------------------------------------------------
// Run-length level decoder package
// Shared widths, codes, record types and saturating arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlld_pkg;

    localparam int COUNT_BITS      = 32;
    localparam int RUN_BITS        = 32;
    localparam int TOTAL_BITS      = 32;
    localparam int LEVEL_BITS      = 8;
    localparam int VALUE_BITS      = 16;
    localparam int TABLE_DEPTH     = 255;
    localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS   = FIFO_PTR_BITS + 1;
    localparam int INFLIGHT_BITS   = 3;
    localparam int PADDR_BITS      = 4;
    localparam int REG_IDX_BITS    = 2;
    localparam int PDATA_BITS      = 32;

    typedef logic [COUNT_BITS-1:0]      count_t;
    typedef logic [LEVEL_BITS-1:0]      level_t;
    typedef logic [VALUE_BITS-1:0]      value_t;
    typedef logic [TABLE_ADDR_BITS-1:0] taddr_t;
    typedef logic [1:0]                 status_t;

    localparam level_t  LEVEL_CODE_MAX  = 8'd255;
    localparam level_t  TABLE_DEPTH_LV  = LEVEL_BITS'(TABLE_DEPTH);
    localparam level_t  BPV_PACKED      = 8'd8;
    localparam level_t  MAX_LEVEL_RESET = 8'd1;
    localparam level_t  BPV_RESET       = 8'd8;

    localparam logic OP_TABLE_LOAD = 1'b0;
    localparam logic OP_DATA       = 1'b1;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_WIDTH = 2'd1;
    localparam status_t STATUS_OVERRUN   = 2'd2;
    localparam status_t STATUS_UNDERRUN  = 2'd3;

    localparam logic [REG_IDX_BITS-1:0] REG_MAX_LEVEL      = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PIXEL_TOTAL    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BITS_PER_VALUE = 2'd2;

    typedef struct packed {
        logic   valid;
        logic   has_a;
        logic   has_b;
        logic   b_has_run;
        logic   b_unit;
        level_t lev_a;
        level_t lev_b;
        count_t acc;
        count_t pend;
    } front_s1_t;

    typedef struct packed {
        value_t                rep_value;
        logic                  missing;
        logic [RUN_BITS-1:0]   run_length;
        status_t               status;
        logic                  final_record;
    } record_t;

    typedef struct packed {
        logic    push_a;
        logic    push_b;
        record_t rec_a;
        record_t rec_b;
    } push_t;

    function automatic count_t sat_add(count_t a, count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic count_t sat_inc_sum(count_t a, count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b} + {{COUNT_BITS{1'b0}}, 1'b1};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic count_t sat_mul_byte(count_t a, level_t b);
        logic [COUNT_BITS+LEVEL_BITS-1:0] p;
        p = {{LEVEL_BITS{1'b0}}, a} * {{COUNT_BITS{1'b0}}, b};
        return (|p[COUNT_BITS+LEVEL_BITS-1:COUNT_BITS]) ? '1 : p[COUNT_BITS-1:0];
    endfunction

    function automatic taddr_t level_addr(level_t lev);
        return (lev < TABLE_DEPTH_LV) ? lev[TABLE_ADDR_BITS-1:0] : '0;
    endfunction

    function automatic status_t status_of(count_t done, logic [TOTAL_BITS-1:0] total,
                                          level_t bpv, logic fin);
        status_t st;
        if (bpv != BPV_PACKED)
            st = STATUS_BAD_WIDTH;
        else if (done > total)
            st = STATUS_OVERRUN;
        else if (fin && (done < total))
            st = STATUS_UNDERRUN;
        else
            st = STATUS_OK;
        return st;
    endfunction

endpackage

`default_nettype wire

/* design/rlld_level_ram.sv */
// ----------------------------------------------------------------------------
// Level table RAM
// One write port, two registered read ports for representative values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlld_level_ram import rlld_pkg::*; (
    input  wire          clk,
    input  wire          we,
    input  wire taddr_t  waddr,
    input  wire value_t  wdata,
    input  wire          re,
    input  wire taddr_t  raddr_a,
    input  wire taddr_t  raddr_b,
    output value_t       rdata_a,
    output value_t       rdata_b
);

    value_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

/* design/rlld_front.sv */
// ----------------------------------------------------------------------------
// Run tracker
// Holds the open run, folds in run-length digits and issues table reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_level_decoder_core_macros.svh"

module rlld_front import rlld_pkg::*; (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          data_take,
    input  wire level_t  data_byte,
    input  wire          end_of_field,
    input  wire level_t  max_level,
    output front_s1_t    s1,
    output logic         rd_en,
    output taddr_t       raddr_a,
    output taddr_t       raddr_b
);

    level_t    pending_level_reg, pending_level_next;
    logic      pending_valid_reg, pending_valid_next;
    count_t    acc_reg, acc_next;
    count_t    pend_reg, pend_next;
    count_t    pw_reg, pw_next;
    front_s1_t s1_reg, s1_next;

    logic      is_digit;
    level_t    digit;
    level_t    base;
    count_t    dig_acc;
    count_t    dig_pend;
    count_t    dig_pw;

    always_comb
    begin
        is_digit = data_byte > max_level;
        digit    = data_byte - max_level - 8'd1;
        base     = LEVEL_CODE_MAX - max_level;
        dig_acc  = sat_add(acc_reg, pend_reg);
        dig_pend = sat_mul_byte(pw_reg, digit);
        dig_pw   = sat_mul_byte(pw_reg, base);

        pending_level_next = pending_level_reg;
        pending_valid_next = pending_valid_reg;
        acc_next           = acc_reg;
        pend_next          = pend_reg;
        pw_next            = pw_reg;

        if (data_take)
        begin
            if (is_digit)
            begin
                if (pending_valid_reg)
                begin
                    acc_next  = dig_acc;
                    pend_next = dig_pend;
                    pw_next   = dig_pw;
                end
            end
            else
            begin
                pending_level_next = data_byte;
                pending_valid_next = 1'b1;
                acc_next           = '0;
                pend_next          = '0;
                pw_next            = count_t'(1);
            end
            if (end_of_field)
            begin
                pending_level_next = '0;
                pending_valid_next = 1'b0;
                acc_next           = '0;
                pend_next          = '0;
                pw_next            = count_t'(1);
            end
        end

        s1_next.valid     = data_take;
        s1_next.has_a     = !is_digit && pending_valid_reg;
        s1_next.has_b     = end_of_field;
        s1_next.b_has_run = !is_digit || pending_valid_reg;
        s1_next.b_unit    = !is_digit;
        s1_next.lev_a     = pending_level_reg;
        s1_next.lev_b     = is_digit ? pending_level_reg : data_byte;
        s1_next.acc       = is_digit ? dig_acc : acc_reg;
        s1_next.pend      = is_digit ? dig_pend : pend_reg;

        rd_en   = data_take;
        raddr_a = level_addr(pending_level_reg);
        raddr_b = level_addr(s1_next.lev_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_level_reg <= '0;
            pending_valid_reg <= 1'b0;
            acc_reg           <= '0;
            pend_reg          <= '0;
            pw_reg            <= count_t'(1);
            s1_reg            <= '0;
        end
        else
        begin
            pending_level_reg <= pending_level_next;
            pending_valid_reg <= pending_valid_next;
            acc_reg           <= acc_next;
            pend_reg          <= pend_next;
            pw_reg            <= pw_next;
            s1_reg            <= s1_next;
        end
    end

    assign s1 = s1_reg;

    `RLLD_ASSERT_NEXT(a_eof_closes_run, data_take && end_of_field, !pending_valid_reg && (pw_reg == count_t'(1)), "field end left a run open")
    `RLLD_ASSERT_NEXT(a_level_opens_run, data_take && !is_digit && !end_of_field, pending_valid_reg && (acc_reg == '0) && (pend_reg == '0), "level byte did not open a clean run")

endmodule

`default_nettype wire

/* design/rlld_back.sv */
// ----------------------------------------------------------------------------
// Record builder
// Forms run records, tracks decoded pixels and sets the field status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_level_decoder_core_macros.svh"

module rlld_back import rlld_pkg::*; (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire front_s1_t        s1,
    input  wire value_t           rdata_a,
    input  wire value_t           rdata_b,
    input  wire [TOTAL_BITS-1:0]  pixel_total,
    input  wire level_t           bits_per_value,
    output push_t                 push,
    output logic [INFLIGHT_BITS-1:0] inflight
);

    count_t run_main;
    count_t run_b_s1;
    value_t rep_a_s1, rep_b_s1;
    logic   miss_a_s1, miss_b_s1;

    logic   has_a_reg, has_a_next;
    logic   has_b_reg, has_b_next;
    value_t rep_a_reg, rep_b_reg;
    logic   miss_a_reg, miss_b_reg;
    count_t run_a_reg, run_b_reg;
    count_t pd_reg, pd_next;

    count_t sum0, sum1, done_b;

    always_comb
    begin
        run_main  = sat_inc_sum(s1.acc, s1.pend);
        miss_a_s1 = (s1.lev_a == '0);
        rep_a_s1  = (miss_a_s1 || (s1.lev_a >= TABLE_DEPTH_LV)) ? '0 : rdata_a;
        miss_b_s1 = s1.b_has_run && (s1.lev_b == '0);
        rep_b_s1  = (!s1.b_has_run || (s1.lev_b == '0) || (s1.lev_b >= TABLE_DEPTH_LV))
                    ? '0 : rdata_b;
        if (!s1.b_has_run)
            run_b_s1 = '0;
        else if (s1.b_unit)
            run_b_s1 = count_t'(1);
        else
            run_b_s1 = run_main;
        has_a_next = s1.valid && s1.has_a;
        has_b_next = s1.valid && s1.has_b;
    end

    always_comb
    begin
        sum0   = sat_add(pd_reg, has_a_reg ? run_a_reg : run_b_reg);
        sum1   = sat_inc_sum(pd_reg, run_a_reg);
        done_b = has_a_reg ? sum1 : sum0;

        if (has_b_reg)
            pd_next = '0;
        else if (has_a_reg)
            pd_next = sum0;
        else
            pd_next = pd_reg;

        push.push_a                 = has_a_reg;
        push.rec_a.rep_value        = rep_a_reg;
        push.rec_a.missing          = miss_a_reg;
        push.rec_a.run_length       = RUN_BITS'(run_a_reg);
        push.rec_a.status           = status_of(sum0, pixel_total, bits_per_value, 1'b0);
        push.rec_a.final_record     = 1'b0;
        push.push_b                 = has_b_reg;
        push.rec_b.rep_value        = rep_b_reg;
        push.rec_b.missing          = miss_b_reg;
        push.rec_b.run_length       = RUN_BITS'(run_b_reg);
        push.rec_b.status           = status_of(done_b, pixel_total, bits_per_value, 1'b1);
        push.rec_b.final_record     = 1'b1;

        inflight = INFLIGHT_BITS'(has_a_next) + INFLIGHT_BITS'(has_b_next)
                 + INFLIGHT_BITS'(has_a_reg) + INFLIGHT_BITS'(has_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_a_reg <= 1'b0;
            has_b_reg <= 1'b0;
            pd_reg    <= '0;
        end
        else
        begin
            has_a_reg <= has_a_next;
            has_b_reg <= has_b_next;
            pd_reg    <= pd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_a_reg  <= rep_a_s1;
        miss_a_reg <= miss_a_s1;
        run_a_reg  <= run_main;
        rep_b_reg  <= rep_b_s1;
        miss_b_reg <= miss_b_s1;
        run_b_reg  <= run_b_s1;
    end

    `RLLD_ASSERT_NEXT(a_final_clears_pixels, has_b_reg, pd_reg == '0, "pixel count kept past field end")
    `RLLD_ASSERT_IMPLY(a_pair_unit_run, has_a_reg && has_b_reg, run_b_reg == count_t'(1), "closing run after level byte is not one pixel")

endmodule

`default_nettype wire

/* design/rlld_out_fifo.sv */
// ----------------------------------------------------------------------------
// Record queue
// Takes up to two records per cycle and hands them out one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_level_decoder_core_macros.svh"

module rlld_out_fifo import rlld_pkg::*; (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire push_t                push,
    input  wire                       out_ready,
    output logic                      out_valid,
    output record_t                   head,
    output logic [FIFO_CNT_BITS-1:0]  count
);

    record_t                    entries [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0]   count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_inc;
    logic [1:0]                 n_push;
    logic                       pop;
    logic [FIFO_CNT_BITS:0]     fill_after;
    record_t                    first_rec;

    always_comb
    begin
        n_push      = 2'(push.push_a) + 2'(push.push_b);
        pop         = out_valid && out_ready;
        wr_ptr_inc  = wr_ptr_reg + FIFO_PTR_BITS'(1);
        first_rec   = push.push_a ? push.rec_a : push.rec_b;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(pop);
        fill_after  = {1'b0, count_reg} + (FIFO_CNT_BITS + 1)'(n_push);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a || push.push_b)
        begin
            entries[wr_ptr_reg] <= first_rec;
        end
        if (push.push_a && push.push_b)
        begin
            entries[wr_ptr_inc] <= push.rec_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

    `RLLD_ASSERT_IMPLY(a_no_overflow, push.push_a || push.push_b, fill_after <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH), "record queue overflow")

endmodule

`default_nettype wire

/* design/run_length_level_decoder_core.sv */
// ----------------------------------------------------------------------------
// Run-length level decoder core
// Order: a run's closing byte is registered with its table reads, the record builder then
//   registers its record for the queue, and a field end's second record follows the first.
// Throughput: one item per cycle when in_ready; a 16x255 table RAM with two read ports
//   serves both records of a field-end byte, and an 8-entry record queue absorbs stalls.
// Reset clears run, pixel count and queue, presets config registers; level table is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module run_length_level_decoder_core import rlld_pkg::*; (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [PADDR_BITS-1:0]   paddr,
    input  wire [PDATA_BITS-1:0]   pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    opcode,
    input  wire level_t            table_index,
    input  wire value_t            table_value,
    input  wire level_t            data_byte,
    input  wire                    end_of_field,
    output logic                   out_valid,
    input  wire                    out_ready,
    output value_t                 rep_value,
    output logic                   missing,
    output logic [RUN_BITS-1:0]    run_length,
    output status_t                status,
    output logic                   final_record
);

    level_t                   max_level_reg, max_level_next;
    logic [TOTAL_BITS-1:0]    pixel_total_reg, pixel_total_next;
    level_t                   bpv_reg, bpv_next;

    logic                     cfg_wr;
    logic [REG_IDX_BITS-1:0]  reg_idx;
    logic                     in_accept;
    logic                     load_take;
    logic                     data_take;
    logic [FIFO_CNT_BITS:0]   reserved;

    front_s1_t                s1;
    logic                     rd_en;
    taddr_t                   raddr_a, raddr_b;
    value_t                   rdata_a, rdata_b;
    push_t                    push;
    logic [INFLIGHT_BITS-1:0] inflight;
    logic [FIFO_CNT_BITS-1:0] fifo_count;
    record_t                  head;

    always_comb
    begin
        pready  = 1'b1;
        cfg_wr  = psel && penable && pwrite && pready;
        reg_idx = paddr[PADDR_BITS-1:2];

        max_level_next   = max_level_reg;
        pixel_total_next = pixel_total_reg;
        bpv_next         = bpv_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAX_LEVEL:      max_level_next   = pwdata[LEVEL_BITS-1:0];
                REG_PIXEL_TOTAL:    pixel_total_next = pwdata[TOTAL_BITS-1:0];
                REG_BITS_PER_VALUE: bpv_next         = pwdata[LEVEL_BITS-1:0];
                default:            ;
            endcase
        end

        case (reg_idx)
            REG_MAX_LEVEL:      prdata = PDATA_BITS'(max_level_reg);
            REG_PIXEL_TOTAL:    prdata = PDATA_BITS'(pixel_total_reg);
            REG_BITS_PER_VALUE: prdata = PDATA_BITS'(bpv_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg   <= MAX_LEVEL_RESET;
            pixel_total_reg <= '0;
            bpv_reg         <= BPV_RESET;
        end
        else
        begin
            max_level_reg   <= max_level_next;
            pixel_total_reg <= pixel_total_next;
            bpv_reg         <= bpv_next;
        end
    end

    always_comb
    begin
        reserved  = {1'b0, fifo_count} + (FIFO_CNT_BITS + 1)'(inflight);
        in_ready  = reserved <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH - 2);
        in_accept = in_valid && in_ready;
        load_take = in_accept && (opcode == OP_TABLE_LOAD) && (table_index < TABLE_DEPTH_LV);
        data_take = in_accept && (opcode == OP_DATA);
    end

    rlld_level_ram u_ram (
        .clk     (clk),
        .we      (load_take),
        .waddr   (level_addr(table_index)),
        .wdata   (table_value),
        .re      (rd_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    rlld_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_take    (data_take),
        .data_byte    (data_byte),
        .end_of_field (end_of_field),
        .max_level    (max_level_reg),
        .s1           (s1),
        .rd_en        (rd_en),
        .raddr_a      (raddr_a),
        .raddr_b      (raddr_b)
    );

    rlld_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1             (s1),
        .rdata_a        (rdata_a),
        .rdata_b        (rdata_b),
        .pixel_total    (pixel_total_reg),
        .bits_per_value (bpv_reg),
        .push           (push),
        .inflight       (inflight)
    );

    rlld_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign rep_value    = head.rep_value;
    assign missing      = head.missing;
    assign run_length   = head.run_length;
    assign status       = head.status;
    assign final_record = head.final_record;

endmodule

`default_nettype wire

/* bench/tb_run_length_level_decoder_core.sv */
// ----------------------------------------------------------------------------
// Run-length level decoder core testbench
// Drives table loads and packed bytes over a valid/ready channel and programs
// the registers over APB. A short directed script covers the corner cases;
// after the level table is filled, random fields follow. Every record leaving
// the core is compared field by field to typed or cycle-free decoder records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_run_length_level_decoder_core;
    import rlld_pkg::*;

    localparam int ITEMS = 1550;
    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

    typedef struct {
        bit                      is_reg;
        logic [REG_IDX_BITS-1:0] reg_idx;
        logic [PDATA_BITS-1:0]   reg_val;
        logic                    op;
        level_t                  idx;
        value_t                  val;
        level_t                  pb;
        logic                    eof;
        int                      n_typed;
        record_t                 r0;
        record_t                 r1;
    } step_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [PADDR_BITS-1:0] paddr        = '0;
    logic [PDATA_BITS-1:0] pwdata       = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  opcode       = OP_TABLE_LOAD;
    level_t                table_index  = '0;
    value_t                table_value  = '0;
    level_t                data_byte    = '0;
    logic                  end_of_field = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    value_t                rep_value;
    logic                  missing;
    logic [RUN_BITS-1:0]   run_length;
    status_t               status;
    logic                  final_record;

    record_t records_due[$];
    step_t   typed_due[$];
    int      items_done = 0;
    int      mismatches = 0;
    bit      steady     = 1'b0;

    value_t           lvl_val [0:TABLE_DEPTH-1];
    level_t           run_level     = '0;
    bit               run_open      = 1'b0;
    count_t           run_sum       = '0;
    count_t           digit_weight  = 1;
    count_t           pix_sum       = '0;
    level_t           cfg_max_level = MAX_LEVEL_RESET;
    logic [31:0]      cfg_total     = '0;
    level_t           cfg_bpv       = BPV_RESET;

    run_length_level_decoder_core DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("run_length_level_decoder_core verification failed");
        $finish;
    end

    function automatic count_t add_sat(count_t a, count_t b);
        longint unsigned s;
        s = 64'(a) + 64'(b);
        return (s > CNT_MAX) ? '1 : count_t'(s);
    endfunction

    function automatic count_t mul_sat(count_t a, count_t b);
        longint unsigned s;
        s = 64'(a) * 64'(b);
        return (s > CNT_MAX) ? '1 : count_t'(s);
    endfunction

    function automatic record_t close_run(bit has_run, bit fin);
        record_t r;
        count_t  len;
        count_t  total_now;
        len         = has_run ? add_sat(run_sum, 1) : '0;
        total_now   = add_sat(pix_sum, len);
        r.rep_value = '0;
        r.missing   = 1'b0;
        if (has_run)
        begin
            if (run_level == 0)
                r.missing = 1'b1;
            else if (run_level < TABLE_DEPTH)
                r.rep_value = lvl_val[run_level];
        end
        r.run_length = len;
        if (cfg_bpv != BPV_PACKED)
            r.status = STATUS_BAD_WIDTH;
        else if (total_now > cfg_total)
            r.status = STATUS_OVERRUN;
        else if (fin && total_now < cfg_total)
            r.status = STATUS_UNDERRUN;
        else
            r.status = STATUS_OK;
        r.final_record = fin;
        pix_sum        = total_now;
        return r;
    endfunction

    function automatic int decode_item(logic op, level_t idx, value_t val, level_t pb,
                                       logic eof, output record_t o0, output record_t o1);
        int n;
        n  = 0;
        o0 = '0;
        o1 = '0;
        if (op == OP_TABLE_LOAD)
        begin
            if (idx < TABLE_DEPTH)
                lvl_val[idx] = val;
            return 0;
        end
        if (pb > cfg_max_level)
        begin
            if (run_open)
            begin
                run_sum      = add_sat(run_sum,
                                       mul_sat(count_t'(pb - cfg_max_level - 8'd1), digit_weight));
                digit_weight = mul_sat(digit_weight, count_t'(8'd255 - cfg_max_level));
            end
        end
        else
        begin
            if (run_open)
            begin
                o0 = close_run(1'b1, 1'b0);
                n  = 1;
            end
            run_level    = pb;
            run_open     = 1'b1;
            run_sum      = '0;
            digit_weight = 1;
        end
        if (eof)
        begin
            if (n == 0)
                o0 = close_run(run_open, 1'b1);
            else
                o1 = close_run(run_open, 1'b1);
            n++;
            run_open     = 1'b0;
            run_level    = '0;
            run_sum      = '0;
            digit_weight = 1;
            pix_sum      = '0;
        end
        return n;
    endfunction

    function automatic record_t rec(value_t rep, logic miss, logic [31:0] run, status_t st,
                                    logic fin);
        record_t r;
        r.rep_value    = rep;
        r.missing      = miss;
        r.run_length   = run;
        r.status       = st;
        r.final_record = fin;
        return r;
    endfunction

    function automatic step_t in_step(logic op, level_t idx, value_t val, level_t pb, logic eof);
        step_t s;
        s         = '{default: '0};
        s.op      = op;
        s.idx     = idx;
        s.val     = val;
        s.pb      = pb;
        s.eof     = eof;
        s.n_typed = -1;
        return s;
    endfunction

    function automatic step_t with_result(step_t s, int n, record_t r0, record_t r1);
        s.n_typed = n;
        s.r0      = r0;
        s.r1      = r1;
        return s;
    endfunction

    function automatic step_t reg_step(logic [REG_IDX_BITS-1:0] idx, logic [PDATA_BITS-1:0] v);
        step_t s;
        s         = '{default: '0};
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = v;
        s.n_typed = -1;
        return s;
    endfunction

    function automatic level_t pick_digit(bit near);
        int lo;
        lo = int'(cfg_max_level) + 1;
        if (near)
            return level_t'(lo + $urandom_range(0, (255 - lo < 2) ? 255 - lo : 2));
        return level_t'($urandom_range(lo, 255));
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_item(step_t s, bit counts);
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        typed_due.push_back(s);
        in_valid     <= 1'b1;
        opcode       <= s.op;
        table_index  <= s.idx;
        table_value  <= s.val;
        data_byte    <= s.pb;
        end_of_field <= s.eof;
        do @(posedge clk); while (!in_ready);
        if (counts)
            items_done++;
        steady = (items_done >= 500 && items_done < 800);
    endtask

    task automatic set_reg(logic [REG_IDX_BITS-1:0] idx, logic [PDATA_BITS-1:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (records_due.size() != 0);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MAX_LEVEL:      cfg_max_level = v[7:0];
            REG_PIXEL_TOTAL:    cfg_total     = v;
            REG_BITS_PER_VALUE: cfg_bpv       = v[7:0];
            default:            ;
        endcase
    endtask

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 10);

    always @(posedge clk)
    begin : take_input
        step_t   s;
        record_t p0;
        record_t p1;
        int      n;
        if (rst_n && in_valid && in_ready)
        begin
            s = typed_due.pop_front();
            n = decode_item(opcode, table_index, table_value, data_byte, end_of_field, p0, p1);
            if (s.n_typed >= 0)
            begin
                n  = s.n_typed;
                p0 = s.r0;
                p1 = s.r1;
            end
            if (n > 0)
                records_due.push_back(p0);
            if (n > 1)
                records_due.push_back(p1);
        end
    end

    always @(posedge clk)
    begin : check_output
        record_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (records_due.size() == 0)
                flag_mismatch("record offered with none expected");
            else
            begin
                w = records_due.pop_front();
                if (rep_value !== w.rep_value)
                    flag_mismatch($sformatf("rep_value %h, expected %h", rep_value, w.rep_value));
                if (missing !== w.missing)
                    flag_mismatch($sformatf("missing %b, expected %b", missing, w.missing));
                if (run_length !== w.run_length)
                    flag_mismatch($sformatf("run_length %h, expected %h",
                                            run_length, w.run_length));
                if (status !== w.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, w.status));
                if (final_record !== w.final_record)
                    flag_mismatch($sformatf("final_record %b, expected %b",
                                            final_record, w.final_record));
            end
        end
    end

    initial
    begin
        step_t   plan[$];
        level_t  packed_bytes[$];
        record_t none;
        int      n_runs;
        int      n_dig;
        int      idx;

        none = '0;
        plan.push_back(in_step(OP_TABLE_LOAD, 8'd1, 16'hFFFF, 8'h00, 1'b0));
        plan.push_back(in_step(OP_TABLE_LOAD, 8'd254, 16'h0000, 8'hFF, 1'b1));
        plan.push_back(in_step(OP_TABLE_LOAD, 8'd0, 16'h1234, 8'h00, 1'b0));
        plan.push_back(in_step(OP_TABLE_LOAD, 8'd255, 16'hABCD, 8'h00, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd200, 1'b0));
        plan.push_back(with_result(in_step(OP_DATA, 8'd0, 16'h0, 8'd255, 1'b1), 1,
                                   rec(16'h0, 1'b0, 32'd0, STATUS_OK, 1'b1), none));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd0, 1'b0));
        plan.push_back(with_result(in_step(OP_DATA, 8'd0, 16'h0, 8'd1, 1'b0), 1,
                                   rec(16'h0, 1'b1, 32'd1, STATUS_OVERRUN, 1'b0), none));
        plan.push_back(with_result(in_step(OP_DATA, 8'd0, 16'h0, 8'd255, 1'b1), 1,
                                   rec(16'hFFFF, 1'b0, 32'd254, STATUS_OVERRUN, 1'b1), none));
        plan.push_back(reg_step(REG_MAX_LEVEL, 32'd254));
        plan.push_back(reg_step(REG_PIXEL_TOTAL, 32'hFFFF_FFFF));
        plan.push_back(in_step(OP_DATA, 8'hFF, 16'hFFFF, 8'd254, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'hFF, 16'hFFFF, 8'd255, 1'b0));
        plan.push_back(with_result(in_step(OP_DATA, 8'hFF, 16'hFFFF, 8'd0, 1'b1), 2,
                                   rec(16'h0, 1'b0, 32'd1, STATUS_OK, 1'b0),
                                   rec(16'h0, 1'b1, 32'd1, STATUS_UNDERRUN, 1'b1)));
        plan.push_back(reg_step(REG_BITS_PER_VALUE, 32'd255));
        plan.push_back(reg_step(REG_MAX_LEVEL, 32'd1));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd1, 1'b0));
        repeat (5)
            plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd255, 1'b0));
        plan.push_back(with_result(in_step(OP_DATA, 8'd0, 16'h0, 8'd255, 1'b1), 1,
                                   rec(16'hFFFF, 1'b0, 32'hFFFF_FFFF, STATUS_BAD_WIDTH, 1'b1),
                                   none));
        plan.push_back(reg_step(REG_BITS_PER_VALUE, 32'd8));
        plan.push_back(reg_step(REG_MAX_LEVEL, 32'd128));
        plan.push_back(reg_step(REG_PIXEL_TOTAL, 32'd3));
        plan.push_back(in_step(OP_TABLE_LOAD, 8'd128, 16'h8000, 8'h00, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd128, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd129, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd255, 1'b0));
        plan.push_back(in_step(OP_DATA, 8'd0, 16'h0, 8'd1, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i], 1'b1);
        end

        for (int i = 1; i < TABLE_DEPTH; i++)
            send_item(in_step(OP_TABLE_LOAD, level_t'(i), value_t'($urandom),
                              level_t'($urandom), 1'(i)), 1'b1);

        while (items_done < ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       set_reg(REG_MAX_LEVEL, 32'd1);
                1:       set_reg(REG_MAX_LEVEL, 32'd254);
                default: set_reg(REG_MAX_LEVEL, $urandom_range(1, 254));
            endcase
            case ($urandom_range(0, 3))
                0:       set_reg(REG_PIXEL_TOTAL, $urandom_range(0, 8));
                1:       set_reg(REG_PIXEL_TOTAL, $urandom_range(0, 30));
                2:       set_reg(REG_PIXEL_TOTAL, $urandom);
                default: set_reg(REG_PIXEL_TOTAL, $urandom_range(1, 4));
            endcase
            set_reg(REG_BITS_PER_VALUE,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 32'd8);

            repeat ($urandom_range(6, 16))
            begin
                packed_bytes.delete();
                if ($urandom_range(0, 9) == 0)
                    send_item(in_step(OP_DATA, level_t'($urandom), value_t'($urandom),
                                      pick_digit(1'b0), 1'b0), 1'b0);
                if ($urandom_range(0, 7) == 0)
                begin
                    idx = $urandom_range(0, 255);
                    send_item(in_step(OP_TABLE_LOAD, level_t'(idx), value_t'($urandom),
                                      level_t'($urandom), 1'($urandom)), idx < TABLE_DEPTH);
                end
                n_runs = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
                for (int r = 0; r < n_runs; r++)
                begin
                    packed_bytes.push_back(level_t'($urandom_range(0, cfg_max_level)));
                    n_dig = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                    for (int d = 0; d < n_dig; d++)
                        packed_bytes.push_back(pick_digit($urandom_range(0, 3) != 0));
                end
                if (n_runs == 0 || $urandom_range(0, 9) == 0)
                    packed_bytes.push_back(pick_digit(1'b1));
                foreach (packed_bytes[i])
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(in_step(OP_TABLE_LOAD, level_t'($urandom_range(1, 254)),
                                          value_t'($urandom), level_t'($urandom),
                                          1'($urandom)), 1'b1);
                    send_item(in_step(OP_DATA, level_t'($urandom), value_t'($urandom),
                                      packed_bytes[i], i == packed_bytes.size() - 1), 1'b1);
                end
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (records_due.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && records_due.size() == 0)
            $display("run_length_level_decoder_core verification clean");
        else
            $display("run_length_level_decoder_core verification failed");
        $finish;
    end

endmodule
